// ===== hdl/fpmq_pkg.sv =====
// Package for the four-level priority message queue.
// Holds sizing constants, command codes and the request/response structs.
// No dependencies.
`default_nettype none

package fpmq_pkg;

   // Sizing
   localparam int FIFO_DEPTH  = 32;  // entries per level, 2..256
   localparam int LEVELS      = 4;   // priority levels, 2..4
   localparam int LEVEL_SHIFT = 27;  // identifier bits 28:27 carry the level
   localparam int LEVEL_BITS  = 2;

   localparam int ID_W      = 29;
   localparam int DATA_W    = 64;
   localparam int ENTRY_W   = ID_W + DATA_W;
   localparam int STORE_D   = LEVELS * FIFO_DEPTH;
   localparam int ADDR_W    = $clog2(STORE_D);
   localparam int PTR_W     = $clog2(FIFO_DEPTH);
   localparam int CNT_W     = $clog2(FIFO_DEPTH + 1);
   localparam int LVL_W     = $clog2(LEVELS);

   // Commands
   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   typedef struct packed {
      logic              cmd;
      logic [ID_W-1:0]   identifier;
      logic [DATA_W-1:0] payload;
   } req_type;

   typedef struct packed {
      logic              accepted;
      logic              out_valid;
      logic [ID_W-1:0]   out_identifier;
      logic [DATA_W-1:0] out_payload;
      logic              all_empty;
   } rsp_type;

endpackage : fpmq_pkg

`default_nettype wire

// ===== hdl/fpmq_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module fpmq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : fpmq_ram

`default_nettype wire

// ===== hdl/four_level_priority_message_queue.sv =====
// Top level of the four-level strict-priority message queue.
// Depends on fpmq_pkg (constants, structs) and fpmq_ram (message store).
//
//   Channel   Ports                      Handshake
//   request   start, busy, req_item      taken when start && !busy
//   response  rsp_strobe, rsp_item       one cycle per strobe, no stall
//
// Every request is taken at an edge and its response shows on the
// following cycle. busy is always low, so a request can be taken at
// every edge. The pop read goes through the store's registered read
// port, which registers the popped message. Reset is synchronous and
// empties every level at once (pointers and fill counts only; the store
// itself is not cleared). The receiver cannot stall the response.
`default_nettype none

module four_level_priority_message_queue
   import fpmq_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output      logic    busy,
   input  wire req_type req_item,
   output      logic    rsp_strobe,
   output      rsp_type rsp_item
);

   // Per-level ring state
   logic [PTR_W-1:0] head_ff [LEVELS];
   logic [PTR_W-1:0] head_in [LEVELS];
   logic [PTR_W-1:0] tail_ff [LEVELS];
   logic [PTR_W-1:0] tail_in [LEVELS];
   logic [CNT_W-1:0] fill_ff [LEVELS];
   logic [CNT_W-1:0] fill_in [LEVELS];

   // Response registers
   logic rsp_strobe_ff, rsp_strobe_in;
   logic accepted_ff,   accepted_in;
   logic pop_hit_ff,    pop_hit_in;
   logic all_empty_ff,  all_empty_in;

   logic                  take;
   logic [LEVEL_BITS-1:0] raw_lvl;
   logic [LVL_W-1:0]      push_lvl;
   logic [LVL_W-1:0]      pop_lvl;
   logic                  pop_found;
   logic                  do_push;
   logic                  do_pop;
   logic [ADDR_W-1:0]     wr_addr;
   logic [ADDR_W-1:0]     rd_addr;
   logic [ENTRY_W-1:0]    rd_entry;

   // The queue finishes each request in a single pass.
   assign busy = 1'b0;
   assign take = start && !busy;

   // Level from identifier bits 28:27, clamped to the lowest priority when
   // fewer than four levels are built.
   assign raw_lvl = req_item.identifier[LEVEL_SHIFT +: LEVEL_BITS];

   always_comb begin
      if (32'(raw_lvl) >= LEVELS) begin
         push_lvl = LVL_W'(LEVELS - 1);
      end else begin
         push_lvl = LVL_W'(raw_lvl);
      end
   end

   // Priority pick: lowest-numbered level holding anything.
   always_comb begin
      pop_lvl   = '0;
      pop_found = 1'b0;
      for (int l = LEVELS - 1; l >= 0; l--) begin
         if (fill_ff[l] != '0) begin
            pop_lvl   = LVL_W'(l);
            pop_found = 1'b1;
         end
      end
   end

   assign do_push = take && (req_item.cmd == CMD_PUSH) &&
                    (fill_ff[push_lvl] < CNT_W'(FIFO_DEPTH));
   assign do_pop  = take && (req_item.cmd == CMD_POP) && pop_found;

   // Flat store address: level * depth + slot
   assign wr_addr = ADDR_W'(push_lvl) * ADDR_W'(FIFO_DEPTH) + ADDR_W'(tail_ff[push_lvl]);
   assign rd_addr = ADDR_W'(pop_lvl) * ADDR_W'(FIFO_DEPTH) + ADDR_W'(head_ff[pop_lvl]);

   // Next ring state
   always_comb begin
      for (int l = 0; l < LEVELS; l++) begin
         head_in[l] = head_ff[l];
         tail_in[l] = tail_ff[l];
         fill_in[l] = fill_ff[l];
      end
      if (do_push) begin
         if (tail_ff[push_lvl] == PTR_W'(FIFO_DEPTH - 1)) begin
            tail_in[push_lvl] = '0;
         end else begin
            tail_in[push_lvl] = tail_ff[push_lvl] + 1'b1;
         end
         fill_in[push_lvl] = fill_ff[push_lvl] + 1'b1;
      end
      if (do_pop) begin
         if (head_ff[pop_lvl] == PTR_W'(FIFO_DEPTH - 1)) begin
            head_in[pop_lvl] = '0;
         end else begin
            head_in[pop_lvl] = head_ff[pop_lvl] + 1'b1;
         end
         fill_in[pop_lvl] = fill_ff[pop_lvl] - 1'b1;
      end
   end

   // Post-step emptiness
   always_comb begin
      all_empty_in = 1'b1;
      for (int l = 0; l < LEVELS; l++) begin
         if (fill_in[l] != '0) begin
            all_empty_in = 1'b0;
         end
      end
   end

   assign rsp_strobe_in = take;
   assign accepted_in   = do_push;
   assign pop_hit_in    = do_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
         for (int l = 0; l < LEVELS; l++) begin
            head_ff[l] <= '0;
            tail_ff[l] <= '0;
            fill_ff[l] <= '0;
         end
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
         for (int l = 0; l < LEVELS; l++) begin
            head_ff[l] <= head_in[l];
            tail_ff[l] <= tail_in[l];
            fill_ff[l] <= fill_in[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      accepted_ff  <= accepted_in;
      pop_hit_ff   <= pop_hit_in;
      all_empty_ff <= all_empty_in;
   end

   // Message store: identifier in the upper bits, payload below.
   // A pop issued at one edge sees any push written at an earlier edge.
   fpmq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (STORE_D)
   ) u_store (
      .clock   (clock),
      .wr_en   (do_push),
      .wr_addr (wr_addr),
      .wr_data ({req_item.identifier, req_item.payload}),
      .rd_en   (do_pop),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   assign rsp_strobe              = rsp_strobe_ff;
   assign rsp_item.accepted       = accepted_ff;
   assign rsp_item.out_valid      = pop_hit_ff;
   assign rsp_item.out_identifier = pop_hit_ff ? rd_entry[ENTRY_W-1 -: ID_W] : '0;
   assign rsp_item.out_payload    = pop_hit_ff ? rd_entry[DATA_W-1:0] : '0;
   assign rsp_item.all_empty      = all_empty_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   logic fills_zero;

   always_comb begin
      fills_zero = 1'b1;
      for (int l = 0; l < LEVELS; l++) begin
         if (fill_ff[l] != '0) begin
            fills_zero = 1'b0;
         end
      end
   end

   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      take |=> rsp_strobe)
      else $error("request taken without a response next cycle");

   a_push_pop_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_item.accepted && rsp_item.out_valid))
      else $error("response marks both a stored push and a popped message");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_item.all_empty == fills_zero))
      else $error("all_empty disagrees with the fill counts");

   a_pop_needs_data: assert property (@(posedge clock) disable iff (reset)
      (take && req_item.cmd == CMD_POP && fills_zero) |=> !rsp_item.out_valid)
      else $error("pop of an empty queue returned a message");

   for (genvar g = 0; g < LEVELS; g++) begin : g_fill_chk
      a_fill_bound: assert property (@(posedge clock) disable iff (reset)
         fill_ff[g] <= CNT_W'(FIFO_DEPTH))
         else $error("level fill count beyond its depth");
   end

endmodule : four_level_priority_message_queue

`default_nettype wire
